FILE: rtl/core/lfia_pkg.sv
// lfia_pkg: shared types, codes and helper functions for the lowest free index allocator
// used by lfia_store, lfia_seq and lowest_free_index_allocator_unit; no dependencies
package lfia_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int FIELD_W        = 10;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_ZERO      = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_ABOVE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_PROBE
    } state_t;

    typedef struct packed {
        logic map_rd;
        logic map_wr;
        logic sum_rd;
        logic sum_wr;
    } mem_cmd_t;

    // bits of index inside one bitmap word
    function automatic int word_log(int ib);
        return (ib > 5) ? 5 : ib - 1;
    endfunction

    // bits of row inside one summary word
    function automatic int sum_log(int ib);
        int rb;
        rb = ib - word_log(ib);
        return (rb > 5) ? 5 : rb - 1;
    endfunction

    function automatic logic [4:0] lowest_set(logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lfia_store.sv
// lfia_store: bitmap memory (one bit per index) and row summary memory (one bit per row)
// single port, registered read; depends on lfia_pkg
module lfia_store #(
    parameter int INDEX_BITS = lfia_pkg::INDEX_BITS_DEF
) (
    input  logic clk,
    input  lfia_pkg::mem_cmd_t cmd,
    input  logic [INDEX_BITS-lfia_pkg::word_log(INDEX_BITS)-1:0] map_addr,
    input  logic [(1 << lfia_pkg::word_log(INDEX_BITS))-1:0]      map_wdata,
    output logic [(1 << lfia_pkg::word_log(INDEX_BITS))-1:0]      map_q,
    input  logic [INDEX_BITS-lfia_pkg::word_log(INDEX_BITS)-lfia_pkg::sum_log(INDEX_BITS)-1:0]
                 sum_addr,
    input  logic [(1 << lfia_pkg::sum_log(INDEX_BITS))-1:0]       sum_wdata,
    output logic [(1 << lfia_pkg::sum_log(INDEX_BITS))-1:0]       sum_q
);

    localparam int WORD_LOG   = lfia_pkg::word_log(INDEX_BITS);
    localparam int WORD_W     = 1 << WORD_LOG;
    localparam int ROW_BITS   = INDEX_BITS - WORD_LOG;
    localparam int ROWS       = 1 << ROW_BITS;
    localparam int SUM_LOG    = lfia_pkg::sum_log(INDEX_BITS);
    localparam int SUM_W      = 1 << SUM_LOG;
    localparam int SUM_ADDR_W = ROW_BITS - SUM_LOG;
    localparam int SUM_DEPTH  = 1 << SUM_ADDR_W;

    logic [WORD_W-1:0] map_mem [ROWS];
    logic [SUM_W-1:0]  sum_mem [SUM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.map_wr)
        begin
            map_mem[map_addr] <= map_wdata;
        end
        if (cmd.map_rd)
        begin
            map_q <= map_mem[map_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_wr)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        if (cmd.sum_rd)
        begin
            sum_q <= sum_mem[sum_addr];
        end
    end

endmodule

FILE: rtl/core/lfia_seq.sv
// lfia_seq: sequencer, high-water mark, pool count and result registers
// drives lfia_store read-modify-write; depends on lfia_pkg
module lfia_seq #(
    parameter int INDEX_BITS = lfia_pkg::INDEX_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [lfia_pkg::MODE_W-1:0] mode_in,
    input  logic [INDEX_BITS-1:0] idx_in,
    output logic busy,
    output logic done,
    output lfia_pkg::status_t status_out,
    output logic [INDEX_BITS-1:0] granted_out,
    output logic pooled_out,
    output logic [INDEX_BITS-1:0] high_water_out,
    output logic [INDEX_BITS-1:0] count_out,
    output lfia_pkg::mem_cmd_t cmd,
    output logic [INDEX_BITS-lfia_pkg::word_log(INDEX_BITS)-1:0] map_addr,
    output logic [(1 << lfia_pkg::word_log(INDEX_BITS))-1:0]      map_wdata,
    input  logic [(1 << lfia_pkg::word_log(INDEX_BITS))-1:0]      map_q,
    output logic [INDEX_BITS-lfia_pkg::word_log(INDEX_BITS)-lfia_pkg::sum_log(INDEX_BITS)-1:0]
                 sum_addr,
    output logic [(1 << lfia_pkg::sum_log(INDEX_BITS))-1:0]       sum_wdata,
    input  logic [(1 << lfia_pkg::sum_log(INDEX_BITS))-1:0]       sum_q
);

    localparam int WORD_LOG   = lfia_pkg::word_log(INDEX_BITS);
    localparam int WORD_W     = 1 << WORD_LOG;
    localparam int ROW_BITS   = INDEX_BITS - WORD_LOG;
    localparam int SUM_LOG    = lfia_pkg::sum_log(INDEX_BITS);
    localparam int SUM_W      = 1 << SUM_LOG;
    localparam int SUM_ADDR_W = ROW_BITS - SUM_LOG;
    localparam int SPOS_W     = (SUM_LOG > 0) ? SUM_LOG : 1;

    localparam logic [INDEX_BITS-1:0] TOP_INDEX  = {INDEX_BITS{1'b1}};
    localparam logic [ROW_BITS-1:0]   SPOS_MASK  = ROW_BITS'(SUM_W - 1);
    localparam logic [SUM_ADDR_W-1:0] LAST_SADDR = {SUM_ADDR_W{1'b1}};

    lfia_pkg::state_t  state_reg, state_next;
    lfia_pkg::status_t status_reg, status_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic free_reg, free_next;
    logic [SUM_ADDR_W-1:0] addr_reg, addr_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [SUM_W-1:0] sum_word_reg, sum_word_next;
    logic [INDEX_BITS-1:0] hw_reg, hw_next;
    logic [INDEX_BITS-1:0] cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0] granted_reg, granted_next;
    logic pooled_reg, pooled_next;
    logic valid_reg, valid_next;

    // address split of the incoming and the held index
    logic [ROW_BITS-1:0]   in_row, cur_row;
    logic [SUM_ADDR_W-1:0] in_saddr, cur_saddr, take_saddr;
    logic [WORD_W-1:0]     cur_wbit;
    logic [SUM_W-1:0]      cur_sbit, take_sbit;
    logic                  cur_row_live, cur_pooled;
    logic [WORD_W-1:0]     cur_word;

    // lowest set bits for the allocate path
    logic [SPOS_W-1:0]   found_spos;
    logic [ROW_BITS-1:0] found_row;
    logic [WORD_LOG-1:0] take_wpos;
    logic [WORD_W-1:0]   take_word;

    lfia_pkg::mode_t mode_sel;

    assign mode_sel   = lfia_pkg::mode_t'(mode_in);
    assign in_row     = ROW_BITS'(idx_in >> WORD_LOG);
    assign in_saddr   = SUM_ADDR_W'(in_row >> SUM_LOG);
    assign cur_row    = ROW_BITS'(idx_reg >> WORD_LOG);
    assign cur_saddr  = SUM_ADDR_W'(cur_row >> SUM_LOG);
    assign cur_wbit   = WORD_W'(1) << WORD_LOG'(idx_reg);
    assign cur_sbit   = SUM_W'(1) << SPOS_W'(cur_row & SPOS_MASK);
    assign cur_row_live = |(sum_q & cur_sbit);
    assign cur_word   = cur_row_live ? map_q : '0;
    assign cur_pooled = |(cur_word & cur_wbit);

    assign found_spos = SPOS_W'(lfia_pkg::lowest_set(32'(sum_q)));
    assign found_row  = ROW_BITS'((ROW_BITS'(addr_reg) << SUM_LOG) | ROW_BITS'(found_spos));
    assign take_wpos  = WORD_LOG'(lfia_pkg::lowest_set(32'(map_q)));
    assign take_word  = map_q & ~(WORD_W'(1) << take_wpos);
    assign take_saddr = SUM_ADDR_W'(row_reg >> SUM_LOG);
    assign take_sbit  = SUM_W'(1) << SPOS_W'(row_reg & SPOS_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lfia_pkg::S_CLEAR;
            addr_reg   <= '0;
            hw_reg     <= '0;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            hw_reg     <= hw_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        free_reg     <= free_next;
        row_reg      <= row_next;
        sum_word_reg <= sum_word_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        pooled_reg   <= pooled_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfia_pkg::S_CLEAR:
            begin
                if (addr_reg == LAST_SADDR)
                begin
                    state_next = lfia_pkg::S_IDLE;
                end
            end
            lfia_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode_sel)
                        lfia_pkg::MODE_ALLOC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = lfia_pkg::S_SCAN;
                            end
                        end
                        lfia_pkg::MODE_FREE:
                        begin
                            if (idx_in != '0)
                            begin
                                state_next = lfia_pkg::S_PROBE;
                            end
                        end
                        lfia_pkg::MODE_CHECK: state_next = lfia_pkg::S_PROBE;
                        lfia_pkg::MODE_NONE:  state_next = lfia_pkg::S_IDLE;
                    endcase
                end
            end
            lfia_pkg::S_SCAN:
            begin
                if (sum_q != '0)
                begin
                    state_next = lfia_pkg::S_TAKE;
                end
            end
            lfia_pkg::S_TAKE:  state_next = lfia_pkg::S_IDLE;
            lfia_pkg::S_PROBE: state_next = lfia_pkg::S_IDLE;
            default:           state_next = lfia_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        map_addr      = cur_row;
        map_wdata     = '0;
        sum_addr      = cur_saddr;
        sum_wdata     = '0;
        idx_next      = idx_reg;
        free_next     = free_reg;
        addr_next     = addr_reg;
        row_next      = row_reg;
        sum_word_next = sum_word_reg;
        hw_next       = hw_reg;
        cnt_next      = cnt_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        pooled_next   = pooled_reg;
        valid_next    = 1'b0;
        unique case (state_reg)
            lfia_pkg::S_CLEAR:
            begin
                cmd.sum_wr = 1'b1;
                sum_addr   = addr_reg;
                addr_next  = addr_reg + SUM_ADDR_W'(1);
            end
            lfia_pkg::S_IDLE:
            begin
                if (start)
                begin
                    idx_next     = idx_in;
                    free_next    = (mode_sel == lfia_pkg::MODE_FREE);
                    status_next  = lfia_pkg::ST_OK;
                    granted_next = '0;
                    pooled_next  = 1'b0;
                    map_addr     = in_row;
                    sum_addr     = in_saddr;
                    unique case (mode_sel)
                        lfia_pkg::MODE_ALLOC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                cmd.sum_rd = 1'b1;
                                sum_addr   = '0;
                                addr_next  = '0;
                            end
                            else if (hw_reg == TOP_INDEX)
                            begin
                                status_next = lfia_pkg::ST_EXHAUSTED;
                                valid_next  = 1'b1;
                            end
                            else
                            begin
                                hw_next      = hw_reg + INDEX_BITS'(1);
                                granted_next = hw_reg + INDEX_BITS'(1);
                                valid_next   = 1'b1;
                            end
                        end
                        lfia_pkg::MODE_FREE:
                        begin
                            if (idx_in == '0)
                            begin
                                status_next = lfia_pkg::ST_ZERO;
                                valid_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.map_rd = 1'b1;
                                cmd.sum_rd = 1'b1;
                            end
                        end
                        lfia_pkg::MODE_CHECK:
                        begin
                            cmd.map_rd = 1'b1;
                            cmd.sum_rd = 1'b1;
                        end
                        lfia_pkg::MODE_NONE:
                        begin
                            valid_next = 1'b1;
                        end
                    endcase
                end
            end
            lfia_pkg::S_SCAN:
            begin
                if (sum_q != '0)
                begin
                    sum_word_next = sum_q;
                    row_next      = found_row;
                    cmd.map_rd    = 1'b1;
                    map_addr      = found_row;
                end
                else
                begin
                    addr_next  = addr_reg + SUM_ADDR_W'(1);
                    cmd.sum_rd = 1'b1;
                    sum_addr   = addr_reg + SUM_ADDR_W'(1);
                end
            end
            lfia_pkg::S_TAKE:
            begin
                cmd.map_wr = 1'b1;
                map_addr   = row_reg;
                map_wdata  = take_word;
                // row emptied, drop its summary bit
                if (take_word == '0)
                begin
                    cmd.sum_wr = 1'b1;
                    sum_addr   = take_saddr;
                    sum_wdata  = sum_word_reg & ~take_sbit;
                end
                cnt_next     = cnt_reg - INDEX_BITS'(1);
                granted_next = {row_reg, take_wpos};
                status_next  = lfia_pkg::ST_OK;
                valid_next   = 1'b1;
            end
            lfia_pkg::S_PROBE:
            begin
                valid_next = 1'b1;
                if (free_reg)
                begin
                    if (cur_pooled)
                    begin
                        status_next = lfia_pkg::ST_DUPLICATE;
                    end
                    else if (idx_reg > hw_reg)
                    begin
                        status_next = lfia_pkg::ST_ABOVE;
                    end
                    else
                    begin
                        cmd.map_wr = 1'b1;
                        map_wdata  = cur_word | cur_wbit;
                        if (!cur_row_live)
                        begin
                            cmd.sum_wr = 1'b1;
                            sum_wdata  = sum_q | cur_sbit;
                        end
                        cnt_next = cnt_reg + INDEX_BITS'(1);
                    end
                end
                else
                begin
                    pooled_next = cur_pooled;
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    assign busy           = (state_reg != lfia_pkg::S_IDLE);
    assign done           = valid_reg;
    assign status_out     = status_reg;
    assign granted_out    = granted_reg;
    assign pooled_out     = pooled_reg;
    assign high_water_out = hw_reg;
    assign count_out      = cnt_reg;

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (state_reg == lfia_pkg::S_IDLE))
        else $error("result strobe outside idle");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hw_reg)
        else $error("pool count above high-water mark");

    a_take_row_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfia_pkg::S_TAKE) |-> (map_q != '0))
        else $error("summary marks an empty bitmap row");

    a_no_zero_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfia_pkg::S_PROBE) |-> !(free_reg && (idx_reg == '0)))
        else $error("return of index zero reached the bitmap");

    a_mark_step: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode_sel == lfia_pkg::MODE_ALLOC) && (cnt_reg == '0)
            && (hw_reg != TOP_INDEX))
        |=> (hw_reg == $past(hw_reg) + INDEX_BITS'(1)) && valid_reg)
        else $error("high-water mark did not advance");
`endif

endmodule

FILE: rtl/core/lowest_free_index_allocator_unit.sv
// lowest_free_index_allocator_unit: top level of the lowest free index allocator
// instantiates lfia_seq and lfia_store; depends on lfia_pkg
//
// One command beat is taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle, marked by done, and a new start is taken during that
// cycle. An allocate from the high-water mark, an exhausted allocate, a return of index
// zero and the unused mode are answered from idle; a return or a check reads bitmap and
// summary memory, then the probe state answers and, for an accepted return, writes back.
// An allocate from the pool reads summary words in turn until one is nonzero (1 to
// 2^(INDEX_BITS - 10) words for INDEX_BITS of 11 and up, 1 to 2 at the default), reads
// the lowest occupied bitmap row, then writes it back in the take state. After reset
// busy stays high while the clearing pass writes all 2^(INDEX_BITS - 10) summary words
// for INDEX_BITS of 11 and up (2 at the default). The receiver cannot stall.
module lowest_free_index_allocator_unit #(
    parameter int INDEX_BITS = lfia_pkg::INDEX_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [lfia_pkg::MODE_W-1:0]   mode,
    input  logic [lfia_pkg::FIELD_W-1:0]  index,
    output logic done,
    output logic [lfia_pkg::STATUS_W-1:0] status,
    output logic [lfia_pkg::FIELD_W-1:0]  granted_index,
    output logic                          is_pooled,
    output logic [lfia_pkg::FIELD_W-1:0]  high_water_out,
    output logic [lfia_pkg::FIELD_W-1:0]  pool_count
);

    localparam int WORD_LOG   = lfia_pkg::word_log(INDEX_BITS);
    localparam int WORD_W     = 1 << WORD_LOG;
    localparam int ROW_BITS   = INDEX_BITS - WORD_LOG;
    localparam int SUM_LOG    = lfia_pkg::sum_log(INDEX_BITS);
    localparam int SUM_W      = 1 << SUM_LOG;
    localparam int SUM_ADDR_W = ROW_BITS - SUM_LOG;

    lfia_pkg::mem_cmd_t cmd;
    lfia_pkg::status_t  status_int;
    logic [ROW_BITS-1:0]   map_addr;
    logic [WORD_W-1:0]     map_wdata, map_q;
    logic [SUM_ADDR_W-1:0] sum_addr;
    logic [SUM_W-1:0]      sum_wdata, sum_q;
    logic [INDEX_BITS-1:0] idx_int, granted_int, hw_int, cnt_int;

    assign idx_int = INDEX_BITS'(index);

    lfia_seq #(
        .INDEX_BITS(INDEX_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .mode_in        (mode),
        .idx_in         (idx_int),
        .busy           (busy),
        .done           (done),
        .status_out     (status_int),
        .granted_out    (granted_int),
        .pooled_out     (is_pooled),
        .high_water_out (hw_int),
        .count_out      (cnt_int),
        .cmd            (cmd),
        .map_addr       (map_addr),
        .map_wdata      (map_wdata),
        .map_q          (map_q),
        .sum_addr       (sum_addr),
        .sum_wdata      (sum_wdata),
        .sum_q          (sum_q)
    );

    lfia_store #(
        .INDEX_BITS(INDEX_BITS)
    ) u_store (
        .clk       (clk),
        .cmd       (cmd),
        .map_addr  (map_addr),
        .map_wdata (map_wdata),
        .map_q     (map_q),
        .sum_addr  (sum_addr),
        .sum_wdata (sum_wdata),
        .sum_q     (sum_q)
    );

    assign status         = status_int;
    assign granted_index  = lfia_pkg::FIELD_W'(granted_int);
    assign high_water_out = lfia_pkg::FIELD_W'(hw_int);
    assign pool_count     = lfia_pkg::FIELD_W'(cnt_int);

endmodule
